[hdl/gzhp_pkg.sv]
// ----------------------------------------------------------------------------
// gzhp_pkg
// Shared types and constants for the gzip member header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

    // Default cap on file name bytes passed out
    localparam int NAME_LIMIT_DEF = 1024;

    // Header bytes and flag masks (RFC 1952)
    localparam logic [7:0] MAGIC1_BYTE  = 8'h1f;
    localparam logic [7:0] MAGIC2_BYTE  = 8'h8b;
    localparam logic [7:0] METHOD_BYTE  = 8'h08;
    localparam logic [7:0] FLG_RSVD     = 8'hE0;
    localparam logic [7:0] FLG_EXTRA    = 8'h04;
    localparam logic [7:0] FLG_NAME     = 8'h08;
    localparam logic [7:0] FLG_COMMENT  = 8'h10;
    localparam logic [7:0] FLG_HCRC     = 8'h02;
    localparam logic [15:0] FIXED_SKIP  = 16'd6;
    localparam logic [15:0] HCRC_LEN    = 16'd2;

    // Per-word status codes
    localparam logic [2:0] ST_HEADER  = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_BAD     = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_PAYLOAD = 3'd4;

    typedef enum logic [3:0] {
        PH_MAGIC1  = 4'd0,
        PH_MAGIC2  = 4'd1,
        PH_METHOD  = 4'd2,
        PH_FLAGS   = 4'd3,
        PH_SKIP6   = 4'd4,
        PH_XLEN_LO = 4'd5,
        PH_XLEN_HI = 4'd6,
        PH_EXTRA   = 4'd7,
        PH_NAME    = 4'd8,
        PH_COMMENT = 4'd9,
        PH_CRC     = 4'd10,
        PH_PAYLOAD = 4'd11,
        PH_BAD     = 4'd12,
        PH_TRUNC   = 4'd13
    } t_phase;

    // Parser state apart from the name counter
    typedef struct packed {
        t_phase      phase;
        logic [15:0] skip_count;
        logic [7:0]  flag_bits;
    } t_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic       name_valid;
        logic [7:0] name_char;
        logic [7:0] payload_byte;
        logic [7:0] header_flags;
    } t_out;

endpackage

[hdl/gzhp_step.sv]
// ----------------------------------------------------------------------------
// gzhp_step
// Combinational header parse of one byte: next state and the result word.
// ----------------------------------------------------------------------------
module gzhp_step #(
    parameter int NAME_LIMIT = gzhp_pkg::NAME_LIMIT_DEF,
    parameter int NAME_W     = $clog2(NAME_LIMIT + 1)
) (
    input  gzhp_pkg::t_state      i_state,
    input  logic [NAME_W-1:0]     i_name_len,
    input  gzhp_pkg::t_in         i_in,
    output gzhp_pkg::t_state      o_state,
    output logic [NAME_W-1:0]     o_name_len,
    output gzhp_pkg::t_out        o_out
);
    import gzhp_pkg::*;

    // First flagged section at or after 'from'
    function automatic t_phase f_enter(input t_phase from, input logic [7:0] flags);
        t_phase ph;
        if (from <= PH_XLEN_LO && (flags & FLG_EXTRA) != 8'd0) begin
            ph = PH_XLEN_LO;
        end else if (from <= PH_NAME && (flags & FLG_NAME) != 8'd0) begin
            ph = PH_NAME;
        end else if (from <= PH_COMMENT && (flags & FLG_COMMENT) != 8'd0) begin
            ph = PH_COMMENT;
        end else if (from <= PH_CRC && (flags & FLG_HCRC) != 8'd0) begin
            ph = PH_CRC;
        end else begin
            ph = PH_PAYLOAD;
        end
        return ph;
    endfunction

    logic [7:0]  b;
    logic [15:0] skip_dec;
    logic [15:0] xlen;
    t_phase      ent_from;
    logic        do_enter;
    t_phase      ent_ph;

    assign b        = i_in.data_byte;
    assign skip_dec = i_state.skip_count - 16'd1;
    assign xlen     = {b, i_state.skip_count[7:0]};

    always_comb begin
        o_state            = i_state;
        o_name_len         = i_name_len;
        o_out              = '0;
        o_out.status       = ST_HEADER;
        ent_from           = PH_PAYLOAD;
        do_enter           = 1'b0;
        ent_ph             = PH_PAYLOAD;

        if (i_state.phase == PH_BAD) begin
            o_out.status = ST_BAD;
        end else if (i_state.phase == PH_TRUNC) begin
            o_out.status = ST_TRUNC;
        end else if (i_state.phase == PH_PAYLOAD) begin
            if (i_in.end_of_input) begin
                o_out.status = ST_DONE;
            end else begin
                o_out.status       = ST_PAYLOAD;
                o_out.payload_byte = b;
            end
        end else if (i_in.end_of_input) begin
            // input ended inside the header
            o_state.phase = PH_TRUNC;
            o_out.status  = ST_TRUNC;
        end else begin
            case (i_state.phase)
                PH_MAGIC1: begin
                    if (b == MAGIC1_BYTE) begin
                        o_state.phase = PH_MAGIC2;
                    end else begin
                        o_state.phase = PH_BAD;
                        o_out.status  = ST_BAD;
                    end
                end
                PH_MAGIC2: begin
                    if (b == MAGIC2_BYTE) begin
                        o_state.phase = PH_METHOD;
                    end else begin
                        o_state.phase = PH_BAD;
                        o_out.status  = ST_BAD;
                    end
                end
                PH_METHOD: begin
                    if (b == METHOD_BYTE) begin
                        o_state.phase = PH_FLAGS;
                    end else begin
                        o_state.phase = PH_BAD;
                        o_out.status  = ST_BAD;
                    end
                end
                PH_FLAGS: begin
                    o_state.flag_bits = b;
                    if ((b & FLG_RSVD) != 8'd0) begin
                        o_state.phase = PH_BAD;
                        o_out.status  = ST_BAD;
                    end else begin
                        o_state.phase      = PH_SKIP6;
                        o_state.skip_count = FIXED_SKIP;
                    end
                end
                PH_SKIP6: begin
                    o_state.skip_count = skip_dec;
                    ent_from           = PH_XLEN_LO;
                    do_enter           = (skip_dec == 16'd0);
                end
                PH_XLEN_LO: begin
                    o_state.skip_count = {8'd0, b};
                    o_state.phase      = PH_XLEN_HI;
                end
                PH_XLEN_HI: begin
                    o_state.skip_count = xlen;
                    ent_from           = PH_NAME;
                    if (xlen == 16'd0) begin
                        do_enter = 1'b1;
                    end else begin
                        o_state.phase = PH_EXTRA;
                    end
                end
                PH_EXTRA: begin
                    o_state.skip_count = skip_dec;
                    ent_from           = PH_NAME;
                    do_enter           = (skip_dec == 16'd0);
                end
                PH_NAME: begin
                    ent_from = PH_COMMENT;
                    if (b == 8'd0) begin
                        do_enter = 1'b1;
                    end else if (i_name_len < NAME_W'(NAME_LIMIT)) begin
                        // pass the name byte, beyond the cap it is dropped
                        o_out.name_valid = 1'b1;
                        o_out.name_char  = b;
                        o_name_len       = i_name_len + NAME_W'(1);
                    end
                end
                PH_COMMENT: begin
                    ent_from = PH_CRC;
                    do_enter = (b == 8'd0);
                end
                PH_CRC: begin
                    o_state.skip_count = skip_dec;
                    ent_from           = PH_PAYLOAD;
                    do_enter           = (skip_dec == 16'd0);
                end
                default: begin
                    o_state.phase = PH_BAD;
                    o_out.status  = ST_BAD;
                end
            endcase

            // move on to the next flagged section
            ent_ph = f_enter(ent_from, i_state.flag_bits);
            if (do_enter) begin
                o_state.phase = ent_ph;
                if (ent_ph == PH_CRC) begin
                    o_state.skip_count = HCRC_LEN;
                end
                o_out.status = (ent_ph == PH_PAYLOAD) ? ST_DONE : ST_HEADER;
            end
        end

        o_out.header_flags = o_state.flag_bits;
    end

endmodule

[hdl/gzip_header_parser.sv]
// ----------------------------------------------------------------------------
// gzip_header_parser
// Checks and walks a gzip member header one byte per word, passes the file
// name out and forwards every byte after the header as payload.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Word
//  in       input      i_in_valid / o_in_ready   t_in  (data_byte, end_of_input)
//  out      output     o_out_valid / i_out_ready t_out (status, name, payload, flags)
//
//  One input word per clock while the skid register is empty; its result
//  word is registered. All parsing of a byte is a single combinational
//  pass from the state registers, so the header state loop sets the rate.
//  A two-entry output (result register plus skid register) keeps input
//  taken while a result waits; input stalls only when both are full.
//  Synchronous active-low reset returns the parser to the first magic byte.
// ----------------------------------------------------------------------------
module gzip_header_parser #(
    parameter int NAME_LIMIT = gzhp_pkg::NAME_LIMIT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gzhp_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output gzhp_pkg::t_out o_out
);
    import gzhp_pkg::*;

    localparam int NAME_W = $clog2(NAME_LIMIT + 1);

    t_state            r_state, n_state;
    logic [NAME_W-1:0] r_name_len, n_name_len;
    t_out              res;
    t_out              r_out, r_skid;
    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    logic              in_fire;
    logic              out_free;

    gzhp_step #(
        .NAME_LIMIT (NAME_LIMIT),
        .NAME_W     (NAME_W)
    ) u_step (
        .i_state    (r_state),
        .i_name_len (r_name_len),
        .i_in       (i_in),
        .o_state    (n_state),
        .o_name_len (n_name_len),
        .o_out      (res)
    );

    assign o_in_ready  = !r_skid_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Parser state advances on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_MAGIC1;
            r_state.skip_count <= '0;
            r_state.flag_bits  <= '0;
            r_name_len         <= '0;
        end else if (in_fire) begin
            r_state    <= n_state;
            r_name_len <= n_name_len;
        end
    end

    // Output / skid occupancy
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = in_fire;
            end
        end else if (in_fire) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Result words, no reset needed
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= res;
            end
        end else if (in_fire) begin
            r_skid <= res;
        end
    end

    // Skid only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    // Bad header is sticky
    a_bad_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_BAD |=> r_state.phase == PH_BAD)
        else $error("left bad header state");

    // Truncation is sticky
    a_trunc_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_TRUNC |=> r_state.phase == PH_TRUNC)
        else $error("left truncated state");

    // Name counter stays within the cap
    a_name_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_name_len <= NAME_W'(NAME_LIMIT))
        else $error("name count over limit");

    // A payload word never carries a name byte
    a_payload_no_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_PAYLOAD) |-> !r_out.name_valid)
        else $error("name byte on payload word");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gzip member header parser. Each run builds one
// gzip member from random choices: flag set, extra field length, name length
// (sometimes past the name cap), comment and header CRC. Most runs parse a
// clean header and then stream payload with scattered end markers. Some runs
// corrupt one header byte or end the input inside the header, and then keep
// feeding noise. A byte-level model predicts every result word. The sender
// works in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gzhp_pkg::*;

    localparam int ITEMS       = 1250;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int SHOW_MAX    = 10;

    // ------------------------------------------------------------------------
    // Header model plus queue of predicted result words
    // ------------------------------------------------------------------------
    class gz_header_checker;
        t_phase      phase;
        logic [15:0] skip_left;
        logic [7:0]  flags_seen;
        logic [11:0] name_count;
        t_out        parse_results_q[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            phase      = PH_MAGIC1;
            skip_left  = '0;
            flags_seen = '0;
            name_count = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        // Move to the first flagged section at or after 'from'
        function logic [2:0] enter_section(t_phase from);
            if (from <= PH_XLEN_LO && (flags_seen & FLG_EXTRA) != 0) begin
                phase = PH_XLEN_LO;
                return ST_HEADER;
            end
            if (from <= PH_NAME && (flags_seen & FLG_NAME) != 0) begin
                phase = PH_NAME;
                return ST_HEADER;
            end
            if (from <= PH_COMMENT && (flags_seen & FLG_COMMENT) != 0) begin
                phase = PH_COMMENT;
                return ST_HEADER;
            end
            if (from <= PH_CRC && (flags_seen & FLG_HCRC) != 0) begin
                phase     = PH_CRC;
                skip_left = HCRC_LEN;
                return ST_HEADER;
            end
            phase = PH_PAYLOAD;
            return ST_DONE;
        endfunction

        // Advance the model by one accepted word and queue its result
        function void note_accepted_byte(t_in w);
            t_out       r;
            logic [7:0] b;
            b        = w.data_byte;
            r        = '0;
            r.status = ST_HEADER;
            if (phase == PH_BAD) begin
                r.status = ST_BAD;
            end else if (phase == PH_TRUNC) begin
                r.status = ST_TRUNC;
            end else if (phase == PH_PAYLOAD) begin
                if (w.end_of_input) begin
                    r.status = ST_DONE;
                end else begin
                    r.status       = ST_PAYLOAD;
                    r.payload_byte = b;
                end
            end else if (w.end_of_input) begin
                phase    = PH_TRUNC;
                r.status = ST_TRUNC;
            end else begin
                case (phase)
                    PH_MAGIC1: begin
                        if (b == MAGIC1_BYTE) phase = PH_MAGIC2;
                        else begin
                            phase    = PH_BAD;
                            r.status = ST_BAD;
                        end
                    end
                    PH_MAGIC2: begin
                        if (b == MAGIC2_BYTE) phase = PH_METHOD;
                        else begin
                            phase    = PH_BAD;
                            r.status = ST_BAD;
                        end
                    end
                    PH_METHOD: begin
                        if (b == METHOD_BYTE) phase = PH_FLAGS;
                        else begin
                            phase    = PH_BAD;
                            r.status = ST_BAD;
                        end
                    end
                    PH_FLAGS: begin
                        flags_seen = b;
                        if ((b & FLG_RSVD) != 0) begin
                            phase    = PH_BAD;
                            r.status = ST_BAD;
                        end else begin
                            phase     = PH_SKIP6;
                            skip_left = FIXED_SKIP;
                        end
                    end
                    PH_SKIP6: begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 0) r.status = enter_section(PH_XLEN_LO);
                    end
                    PH_XLEN_LO: begin
                        skip_left = {8'h00, b};
                        phase     = PH_XLEN_HI;
                    end
                    PH_XLEN_HI: begin
                        skip_left = skip_left | {b, 8'h00};
                        if (skip_left == 0) r.status = enter_section(PH_NAME);
                        else phase = PH_EXTRA;
                    end
                    PH_EXTRA: begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 0) r.status = enter_section(PH_NAME);
                    end
                    PH_NAME: begin
                        if (b == 8'h00) begin
                            r.status = enter_section(PH_COMMENT);
                        end else if (name_count < NAME_LIMIT_DEF) begin
                            r.name_valid = 1'b1;
                            r.name_char  = b;
                            name_count   = name_count + 12'd1;
                        end
                    end
                    PH_COMMENT: begin
                        if (b == 8'h00) r.status = enter_section(PH_CRC);
                    end
                    PH_CRC: begin
                        skip_left = skip_left - 16'd1;
                        if (skip_left == 0) r.status = enter_section(PH_PAYLOAD);
                    end
                    default: begin
                        phase    = PH_BAD;
                        r.status = ST_BAD;
                    end
                endcase
            end
            r.header_flags = flags_seen;
            parse_results_q.push_back(r);
        endfunction

        // Compare one delivered result word with the oldest prediction
        function void check_parse_result(t_out got);
            t_out exp_w;
            if (parse_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result word: status=%0d nv=%0b nc=%02h pb=%02h fl=%02h",
                             got.status, got.name_valid, got.name_char,
                             got.payload_byte, got.header_flags);
                return;
            end
            exp_w = parse_results_q.pop_front();
            checked++;
            if (got.status !== exp_w.status || got.name_valid !== exp_w.name_valid ||
                got.name_char !== exp_w.name_char ||
                got.payload_byte !== exp_w.payload_byte ||
                got.header_flags !== exp_w.header_flags) begin
                mismatches++;
                if (mismatches <= SHOW_MAX) begin
                    $display("word %0d mismatch: exp status=%0d nv=%0b nc=%02h pb=%02h fl=%02h",
                             checked, exp_w.status, exp_w.name_valid, exp_w.name_char,
                             exp_w.payload_byte, exp_w.header_flags);
                    $display("               got status=%0d nv=%0b nc=%02h pb=%02h fl=%02h",
                             got.status, got.name_valid, got.name_char,
                             got.payload_byte, got.header_flags);
                end
            end
        endfunction

        function int unsigned pending();
            return parse_results_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT signals and instance
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_word;
    logic out_valid;
    logic out_ready;
    t_out out_word;

    gz_header_checker hdr_chk = new();
    t_in              member_stream_q[$];
    int               cycle_cnt = 0;

    gzip_header_parser uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word)
    );

    function void queue_byte(input logic [7:0] b, input logic eoi);
        t_in w;
        w.data_byte    = b;
        w.end_of_input = eoi;
        member_stream_q.push_back(w);
    endfunction

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) hdr_chk.check_parse_result(out_word);
    end

    // Receiver: stretches of always-ready, random, mostly-ready and mostly-stalled
    initial begin : rx_stall
        int mode;
        int len;
        out_ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(8, 80);
            repeat (len) begin
                @(posedge i_clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 7) != 0);
                    default: out_ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Build one member, drive it, then wait for the last result
    // ------------------------------------------------------------------------
    initial begin : main_seq
        logic [7:0]  hdr_q[$];
        logic [7:0]  flg;
        logic [15:0] xlen;
        int          nlen;
        int          fault_sel;
        int          pos;
        int          sel;
        int          idx;
        int          burst_left;
        int          gap;

        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;

        // Flag set: each known bit on with odd 3 in 4, ascii bit included
        flg = 8'h00;
        if ($urandom_range(0, 3) != 0) flg = flg | 8'h01;
        if ($urandom_range(0, 3) != 0) flg = flg | FLG_HCRC;
        if ($urandom_range(0, 3) != 0) flg = flg | FLG_EXTRA;
        if ($urandom_range(0, 3) != 0) flg = flg | FLG_NAME;
        if ($urandom_range(0, 3) != 0) flg = flg | FLG_COMMENT;

        hdr_q = {MAGIC1_BYTE, MAGIC2_BYTE, METHOD_BYTE, flg};
        repeat (6) hdr_q.push_back(8'($urandom_range(0, 255)));
        if ((flg & FLG_EXTRA) != 0) begin
            // zero length, short, or long enough to use the high length byte
            sel  = $urandom_range(0, 7);
            xlen = (sel < 2) ? 16'd0 :
                   (sel == 7) ? 16'($urandom_range(256, 280)) : 16'($urandom_range(1, 24));
            hdr_q.push_back(xlen[7:0]);
            hdr_q.push_back(xlen[15:8]);
            repeat (xlen) hdr_q.push_back(8'($urandom_range(0, 255)));
        end
        if ((flg & FLG_NAME) != 0) begin
            // sometimes straddle the name cap
            nlen = ($urandom_range(0, 3) == 0) ? $urandom_range(NAME_LIMIT_DEF - 4,
                                                                 NAME_LIMIT_DEF + 6)
                                               : $urandom_range(0, 24);
            repeat (nlen) hdr_q.push_back(8'($urandom_range(1, 255)));
            hdr_q.push_back(8'h00);
        end
        if ((flg & FLG_COMMENT) != 0) begin
            repeat ($urandom_range(0, 16)) hdr_q.push_back(8'($urandom_range(1, 255)));
            hdr_q.push_back(8'h00);
        end
        if ((flg & FLG_HCRC) != 0) begin
            repeat (2) hdr_q.push_back(8'($urandom_range(0, 255)));
        end

        fault_sel = $urandom_range(0, 7);
        if (fault_sel == 0) begin
            // bad magic, method or reserved flag bit, then noise
            pos = $urandom_range(0, 3);
            if (pos == 3) hdr_q[3] = flg | (8'h20 << $urandom_range(0, 2));
            else hdr_q[pos] = hdr_q[pos] ^ 8'($urandom_range(1, 255));
            for (idx = 0; idx <= pos; idx++) queue_byte(hdr_q[idx], 1'b0);
            while (member_stream_q.size() < ITEMS)
                queue_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
        end else if (fault_sel == 1) begin
            // input ends inside the header: at the start, near the end, or anywhere
            sel = $urandom_range(0, 3);
            pos = (sel == 0) ? 0 :
                  (sel == 1) ? hdr_q.size() - $urandom_range(1, 2) :
                               $urandom_range(0, hdr_q.size() - 1);
            for (idx = 0; idx < pos; idx++) queue_byte(hdr_q[idx], 1'b0);
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
            while (member_stream_q.size() < ITEMS)
                queue_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
        end else begin
            foreach (hdr_q[i]) queue_byte(hdr_q[i], 1'b0);
            // payload extremes and end markers right after the header
            queue_byte(8'h00, 1'b0);
            queue_byte(8'hFF, 1'b0);
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
            queue_byte(8'h80, 1'b0);
            queue_byte(8'h7F, 1'b0);
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
            while (member_stream_q.size() < ITEMS)
                queue_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 31) == 0));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender: random bursts, random gaps, now and then a long burst
        burst_left = 0;
        for (idx = 0; idx < member_stream_q.size(); idx++) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            in_valid <= 1'b1;
            in_word  <= member_stream_q[idx];
            @(posedge i_clk);
            while (!in_ready) @(posedge i_clk);
            hdr_chk.note_accepted_byte(member_stream_q[idx]);
            burst_left--;
        end
        in_valid <= 1'b0;

        while (hdr_chk.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (hdr_chk.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
hdl/gzhp_pkg.sv
hdl/gzhp_step.sv
hdl/gzip_header_parser.sv
dv/tb_top.sv
